// ----- rtl/orqm_pkg.sv -----
// ----------------------------------------------------------------------------
// orqm_pkg: shared types and constants of the ring queue with running mean
// Field widths, transaction payload structs, mode and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package orqm_pkg;

	localparam int QUEUE_CAPACITY_DEF = 8;

	localparam int KEY_W  = 10;
	localparam int RATE_W = 8;
	localparam int MEAN_W = 8;
	localparam int KIND_W = 2;
	localparam int HELD_W = 4;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_MEAN    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]  item_key;
		logic [RATE_W-1:0] item_rate;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [MEAN_W-1:0] mean_rate;
		logic [KEY_W-1:0]  removed_key;
		logic [RATE_W-1:0] removed_rate;
		logic [HELD_W-1:0] held_count;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/orqm_chan_if.sv -----
// ----------------------------------------------------------------------------
// orqm_chan_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface orqm_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

`default_nettype wire

// ----- rtl/orqm_div.sv -----
// ----------------------------------------------------------------------------
// orqm_div: iterative restoring divider for the mean
// Produces one quotient bit per cycle, most significant first; the quotient
// is known to fit in MEAN_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module orqm_div #(
	parameter int DIV_W = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DIV_W-1:0]           dividend,
	input  wire logic [DIV_W-1:0]           divisor,
	output logic                            done,
	output logic [orqm_pkg::MEAN_W-1:0]     quotient
);

	localparam int MEAN_W = orqm_pkg::MEAN_W;
	localparam int STEP_W = $clog2(MEAN_W);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [MEAN_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(MEAN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= divisor << (MEAN_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[MEAN_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/overwriting_ring_queue_mean.sv -----
// ----------------------------------------------------------------------------
// overwriting_ring_queue_mean: overwriting ring queue with running mean
// Holds up to QUEUE_CAPACITY key/rate entries; an insert appends, dropping the
// oldest entry if the queue is full, and reports the rounded mean of the held
// rates; a remove pops the oldest entry.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+----------
//   item     | in  | mode, item_key, item_rate                       | valid/ready
//   result   | out | result_kind, mean_rate, removed_key,            | valid/ready
//            |     | removed_rate, held_count                        |
//
// An insert steps through update, start, wait and finish, the wait set by the
// divider's one quotient bit per cycle; a remove goes from update to finish.
// Only one transaction is in progress at a time; item.ready is high when idle.
// The result register lets the next transaction in while a result waits; a
// stalled result holds the block at its final step.
// Reset clears the pointers, the count and the running sum; no memory pass.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_queue_mean #(
	parameter int QUEUE_CAPACITY = orqm_pkg::QUEUE_CAPACITY_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	orqm_chan_if.sink   item,
	orqm_chan_if.source result
);

	localparam int KEY_W  = orqm_pkg::KEY_W;
	localparam int RATE_W = orqm_pkg::RATE_W;
	localparam int MEAN_W = orqm_pkg::MEAN_W;
	localparam int KIND_W = orqm_pkg::KIND_W;
	localparam int HELD_W = orqm_pkg::HELD_W;
	localparam int SLOTS  = QUEUE_CAPACITY + 1;
	localparam int PTR_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(QUEUE_CAPACITY + 1);
	localparam int SUM_W  = RATE_W + CNT_W;
	localparam int DIV_W  = SUM_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_START  = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t               state_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q;

	logic                 mode_q;
	logic [KEY_W-1:0]     key_q;
	logic [RATE_W-1:0]    rate_q;

	logic [KEY_W+RATE_W-1:0] slot_mem_q [SLOTS];
	logic [KEY_W-1:0]     rd_key_q;
	logic [RATE_W-1:0]    rd_rate_q;

	logic [KIND_W-1:0]    kind_q;
	logic [KEY_W-1:0]     rkey_q;
	logic [RATE_W-1:0]    rrate_q;

	orqm_pkg::res_t       res_q;
	logic                 res_valid_q;

	logic                 accept;
	logic                 is_insert;
	logic                 full;
	logic                 empty;
	logic                 mem_we;
	logic [PTR_W-1:0]     head_next;
	logic [PTR_W-1:0]     tail_next;
	logic                 div_start;
	logic                 div_done;
	logic [MEAN_W-1:0]    div_quo;
	logic [DIV_W-1:0]     dividend;
	logic [DIV_W-1:0]     divisor;
	logic                 res_free;

	assign accept    = item.valid && item.ready;
	assign is_insert = (mode_q == orqm_pkg::MODE_INSERT);
	assign full      = (cnt_q == CNT_W'(QUEUE_CAPACITY));
	assign empty     = (cnt_q == '0);
	assign mem_we    = (state_q == ST_UPDATE) && is_insert;
	assign head_next = (head_q == PTR_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == PTR_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
	assign div_start = (state_q == ST_START);
	assign dividend  = {sum_q, 1'b0} + DIV_W'(cnt_q);
	assign divisor   = DIV_W'({cnt_q, 1'b0});
	assign res_free  = !res_valid_q || result.ready;

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[tail_q] <= {key_q, rate_q};
		end
		{rd_key_q, rd_rate_q} <= slot_mem_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.data.mode;
			key_q  <= item.data.item_key;
			rate_q <= item.data.item_rate;
		end
		if (state_q == ST_UPDATE) begin
			if (is_insert) begin
				kind_q  <= orqm_pkg::KIND_MEAN;
				rkey_q  <= '0;
				rrate_q <= '0;
			end else if (empty) begin
				kind_q  <= orqm_pkg::KIND_EMPTY;
				rkey_q  <= '0;
				rrate_q <= '0;
			end else begin
				kind_q  <= orqm_pkg::KIND_REMOVED;
				rkey_q  <= rd_key_q;
				rrate_q <= rd_rate_q;
			end
		end
		if ((state_q == ST_FINISH) && res_free) begin
			res_q.result_kind  <= kind_q;
			res_q.mean_rate    <= (kind_q == orqm_pkg::KIND_MEAN) ? div_quo : '0;
			res_q.removed_key  <= rkey_q;
			res_q.removed_rate <= rrate_q;
			res_q.held_count   <= HELD_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (is_insert) begin
						// A full queue drops its oldest entry before the append.
						if (full) begin
							head_q <= head_next;
							sum_q  <= sum_q - SUM_W'(rd_rate_q) + SUM_W'(rate_q);
						end else begin
							cnt_q  <= cnt_q + 1'b1;
							sum_q  <= sum_q + SUM_W'(rate_q);
						end
						tail_q  <= tail_next;
						state_q <= ST_START;
					end else begin
						if (!empty) begin
							head_q <= head_next;
							cnt_q  <= cnt_q - 1'b1;
							sum_q  <= sum_q - SUM_W'(rd_rate_q);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	orqm_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

`default_nettype wire

// ----- rtl/orqm_checker.sv -----
// ----------------------------------------------------------------------------
// orqm_checker: port-level checks of the ring queue with running mean
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module orqm_checker #(
	parameter int QUEUE_CAPACITY = orqm_pkg::QUEUE_CAPACITY_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	orqm_chan_if.sink   item,
	orqm_chan_if.source result
);

	localparam int HELD_W = orqm_pkg::HELD_W;

	// A result that is not taken stays offered.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result transaction withdrawn before it was taken");

	// Only one transaction is in progress at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("new transaction accepted while one is in progress");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.result_kind == orqm_pkg::KIND_EMPTY) |->
		(result.data.mean_rate == '0) && (result.data.removed_key == '0) &&
		(result.data.removed_rate == '0) && (result.data.held_count == '0))
		else $error("remove on an empty queue reported nonzero fields");

	a_mean_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.result_kind == orqm_pkg::KIND_MEAN) |->
		(result.data.removed_key == '0) && (result.data.removed_rate == '0) &&
		((QUEUE_CAPACITY >= (1 << HELD_W)) || (result.data.held_count != '0)))
		else $error("insert result carries removed fields or an empty count");

endmodule

bind overwriting_ring_queue_mean orqm_checker #(
	.QUEUE_CAPACITY (QUEUE_CAPACITY)
) u_orqm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the overwriting ring queue with mean
// Drives insert and remove transactions through the item channel with random
// gaps, stalls the result channel at random, and checks every result against
// a cycle-free model of the queue, its running sum and its rounded mean.
// A directed table covers the empty queue, the extremes and overwrites; then
// phases of random traffic with varying insert bias fill and drain the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import orqm_pkg::*;

	localparam int SLOTS      = QUEUE_CAPACITY_DEF + 1;
	localparam int PHASES     = 20;
	localparam int PHASE_LEN  = 98;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_WAIT = 20;
	localparam int SHOW_MAX   = 10;

	typedef struct packed {
		req_t req;
		logic known;
		res_t want;
	} step_row_t;

	typedef struct packed {
		logic known;
		res_t want;
	} hint_t;

	localparam step_row_t DIRECTED [25] = '{
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b1, '{KIND_EMPTY, 8'd0, 10'd0, 8'd0, 4'd0}},
		'{'{MODE_INSERT, 10'h3FF, 8'hFF}, 1'b1, '{KIND_MEAN, 8'd255, 10'd0, 8'd0, 4'd1}},
		'{'{MODE_INSERT, 10'h000, 8'h00}, 1'b1, '{KIND_MEAN, 8'd128, 10'd0, 8'd0, 4'd2}},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b1,
			'{KIND_REMOVED, 8'd0, 10'd1023, 8'd255, 4'd1}},
		'{'{MODE_REMOVE, 10'h3FF, 8'hFF}, 1'b1, '{KIND_REMOVED, 8'd0, 10'd0, 8'd0, 4'd0}},
		'{'{MODE_REMOVE, 10'h2AA, 8'h55}, 1'b1, '{KIND_EMPTY, 8'd0, 10'd0, 8'd0, 4'd0}},
		'{'{MODE_INSERT, 10'h155, 8'hAA}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h2AA, 8'h55}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h001, 8'h80}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h200, 8'h7F}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h155, 8'h01}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h2AA, 8'hFE}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h0F0, 8'hFF}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h30F, 8'h00}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h3FF, 8'hFF}, 1'b0, '0},
		'{'{MODE_INSERT, 10'h000, 8'h01}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h3FF, 8'hFF}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h155, 8'hAA}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h2AA, 8'h55}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h000, 8'h00}, 1'b0, '0},
		'{'{MODE_REMOVE, 10'h3FF, 8'hFF}, 1'b1, '{KIND_EMPTY, 8'd0, 10'd0, 8'd0, 4'd0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	logic calm = 1'b0;
	int stall_left = 0;

	orqm_chan_if #(.data_t(req_t)) item_ch ();
	orqm_chan_if #(.data_t(res_t)) result_ch ();

	assign result_ch.ready = sink_ready;

	overwriting_ring_queue_mean DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #6 clk = ~clk;

	logic [KEY_W-1:0]  queue_keys  [SLOTS];
	logic [RATE_W-1:0] queue_rates [SLOTS];
	int unsigned head_slot = 0;
	int unsigned tail_slot = 0;
	int unsigned rate_total = 0;

	res_t  expected_q [$];
	hint_t hint_q [$];

	int failures = 0;
	int results_seen = 0;
	int inserts = 0;
	int overwrites = 0;
	int removes = 0;
	int empty_removes = 0;
	int idle_cycles = 0;
	int cycles = 0;

	function automatic int unsigned slot_after(int unsigned slot);
		return (slot + 1) % SLOTS;
	endfunction

	function automatic int unsigned entries_held();
		return (tail_slot + SLOTS - head_slot) % SLOTS;
	endfunction

	function automatic res_t queue_step(req_t req);
		res_t res;
		int unsigned count;
		res = '0;
		if (req.mode == MODE_INSERT) begin
			inserts++;
			if (slot_after(tail_slot) == head_slot) begin
				overwrites++;
				rate_total -= queue_rates[head_slot];
				head_slot = slot_after(head_slot);
			end
			queue_keys[tail_slot]  = req.item_key;
			queue_rates[tail_slot] = req.item_rate;
			rate_total += req.item_rate;
			tail_slot = slot_after(tail_slot);
			count = entries_held();
			res.result_kind = KIND_MEAN;
			res.mean_rate   = MEAN_W'((rate_total * 2 + count) / (count * 2));
		end else if (head_slot == tail_slot) begin
			empty_removes++;
			res.result_kind = KIND_EMPTY;
		end else begin
			removes++;
			res.result_kind  = KIND_REMOVED;
			res.removed_key  = queue_keys[head_slot];
			res.removed_rate = queue_rates[head_slot];
			rate_total -= queue_rates[head_slot];
			head_slot = slot_after(head_slot);
		end
		res.held_count = HELD_W'(entries_held());
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_item(req_t req, logic known, res_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hint_q.push_back('{known, want});
		item_ch.valid <= 1'b1;
		item_ch.data  <= req;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_q.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			sink_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			sink_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		hint_t hint;
		if (arst_n) begin
			cycles++;
			idle_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				idle_cycles = 0;
				results_seen++;
				got = result_ch.data;
				if (expected_q.size() == 0) begin
					failures++;
					if (failures <= SHOW_MAX)
						$display("result with no transaction pending: kind %0d held %0d",
							got.result_kind, got.held_count);
				end else begin
					want = expected_q.pop_front();
					if (got.result_kind !== want.result_kind || got.mean_rate !== want.mean_rate
							|| got.removed_key !== want.removed_key
							|| got.removed_rate !== want.removed_rate
							|| got.held_count !== want.held_count) begin
						failures++;
						if (failures <= SHOW_MAX) begin
							$write("mismatch on result %0d (expected/actual): kind %0d/%0d ",
								results_seen, want.result_kind, got.result_kind);
							$display("mean %0d/%0d key %0d/%0d rate %0d/%0d held %0d/%0d",
								want.mean_rate, got.mean_rate, want.removed_key,
								got.removed_key, want.removed_rate, got.removed_rate,
								want.held_count, got.held_count);
						end
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				idle_cycles = 0;
				hint = hint_q.pop_front();
				want = queue_step(item_ch.data);
				expected_q.push_back(hint.known ? hint.want : want);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transaction for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, expected_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		req_t req;
		int insert_pct;
		int roll;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			push_item(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].want);
		hold_until_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 4))
				0: insert_pct = 15;
				1: insert_pct = 40;
				2: insert_pct = 55;
				3: insert_pct = 70;
				default: insert_pct = 90;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				req.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
				req.item_key = KEY_W'($urandom_range(0, 1023));
				roll = $urandom_range(0, 7);
				if (roll == 0)
					req.item_rate = 8'h00;
				else if (roll == 1)
					req.item_rate = 8'hFF;
				else
					req.item_rate = RATE_W'($urandom_range(0, 255));
				push_item(req, 1'b0, '0);
			end
			if (phase % 5 == 2)
				hold_until_drained();
		end
		calm = 1'b0;

		hold_until_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_q.size() != 0)
			failures++;

		$display("Ran %0d inserts (%0d over a full queue), %0d removes, %0d removes when empty.",
			inserts, overwrites, removes, empty_removes);
		$display("Checked %0d results over %0d cycles with %0d failures.",
			results_seen, cycles, failures);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
